[src/rbs_pkg.sv]
package rbs_pkg;

  localparam int Q_WIDTH    = 32;
  localparam int NUM_WIDTH  = 33;
  localparam int THR_WIDTH  = 17;
  localparam int DIST_WIDTH = 31;
  localparam int NUM_AXES   = 3;

  localparam logic signed [Q_WIDTH-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_WIDTH-1:0] Q_MIN = 32'sh8000_0000;

  // what one axis lane hands to the merge stage
  typedef struct packed {
    logic                      par;
    logic                      pmiss;
    logic signed [Q_WIDTH-1:0] tmin;
    logic signed [Q_WIDTH-1:0] tmax;
  } lane_out_t;

endpackage

[src/rbs_ray_if.sv]
interface rbs_ray_if;
  import rbs_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [Q_WIDTH-1:0] origin_x;
  logic signed [Q_WIDTH-1:0] origin_y;
  logic signed [Q_WIDTH-1:0] origin_z;
  logic signed [Q_WIDTH-1:0] dir_x;
  logic signed [Q_WIDTH-1:0] dir_y;
  logic signed [Q_WIDTH-1:0] dir_z;
  logic signed [Q_WIDTH-1:0] box_min_x;
  logic signed [Q_WIDTH-1:0] box_min_y;
  logic signed [Q_WIDTH-1:0] box_min_z;
  logic signed [Q_WIDTH-1:0] box_max_x;
  logic signed [Q_WIDTH-1:0] box_max_y;
  logic signed [Q_WIDTH-1:0] box_max_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                output ready);
endinterface

interface rbs_res_if;
  import rbs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [DIST_WIDTH-1:0]   distance;

  modport source (output valid, hit, distance, input ready);
  modport sink (input valid, hit, distance, output ready);
endinterface

[src/ray_box_slab_intersection_core.sv]
// Ray versus axis-aligned box slab test in signed fixed point. One transaction
// on ray carries origin, direction and box corners; one transaction on res
// returns hit and the hit distance (0 on a miss). A new ray is taken every
// cycle while the pipeline advances; the pipeline is formed by the
// bit-per-stage dividers, two per axis lane, followed by one merge register.
// The whole pipeline holds while a result waits at res and is not taken.
// The parallel threshold is written through cfg_we/cfg_data and resets to 1.
module ray_box_slab_intersection_core import rbs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [THR_WIDTH-1:0] cfg_data,
  rbs_ray_if.sink              ray,
  rbs_res_if.source            res
);

  localparam int LAT = NUM_WIDTH + FRAC_BITS + 3;

  logic [THR_WIDTH-1:0] threshold;
  logic                 en;
  logic [LAT-1:0]       vld;
  lane_out_t            lanes [0:NUM_AXES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_WIDTH'(1);
    end else if (cfg_we) begin
      threshold <= cfg_data;
    end
  end

  // pipeline advances unless the output is held
  assign en        = !res.valid || res.ready;
  assign ray.ready = en;
  assign res.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], ray.valid};
    end
  end

  rbs_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk(clk), .en(en), .thr(threshold), .o(ray.origin_x), .d(ray.dir_x),
    .lo(ray.box_min_x), .hi(ray.box_max_x), .res(lanes[0])
  );
  rbs_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk(clk), .en(en), .thr(threshold), .o(ray.origin_y), .d(ray.dir_y),
    .lo(ray.box_min_y), .hi(ray.box_max_y), .res(lanes[1])
  );
  rbs_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk(clk), .en(en), .thr(threshold), .o(ray.origin_z), .d(ray.dir_z),
    .lo(ray.box_min_z), .hi(ray.box_max_z), .res(lanes[2])
  );

  rbs_merge u_merge (
    .clk(clk), .en(en), .lanes(lanes), .hit(res.hit), .distance(res.distance)
  );

endmodule

[src/rbs_div.sv]
module rbs_div import rbs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [NUM_WIDTH-1:0] num,
  input  logic signed [Q_WIDTH-1:0]   den,
  output logic signed [Q_WIDTH-1:0]   q
);

  localparam int W = NUM_WIDTH + FRAC_BITS;

  logic [Q_WIDTH-1:0]   den_mag;
  logic [NUM_WIDTH-1:0] num_abs;

  logic [Q_WIDTH-1:0] rem_p [0:W];
  logic [W-1:0]       dvd_p [0:W];
  logic [W-1:0]       quo_p [0:W];
  logic [Q_WIDTH-1:0] den_p [0:W];
  logic               neg_p [0:W];

  // operand magnitudes, quotient is formed unsigned and truncates toward zero
  assign num_abs = num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : num;
  assign den_mag = den[Q_WIDTH-1] ? Q_WIDTH'(-den) : den;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_p[0] <= '0;
      dvd_p[0] <= {num_abs, {FRAC_BITS{1'b0}}};
      quo_p[0] <= '0;
      den_p[0] <= den_mag;
      neg_p[0] <= num[NUM_WIDTH-1] ^ den[Q_WIDTH-1];
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [Q_WIDTH:0] cand;
    logic [Q_WIDTH:0] diff;
    logic             ge;
    assign cand = {rem_p[k], dvd_p[k][W-1]};
    assign diff = cand - {1'b0, den_p[k]};
    assign ge   = cand >= {1'b0, den_p[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_p[k+1] <= ge ? diff[Q_WIDTH-1:0] : cand[Q_WIDTH-1:0];
        quo_p[k+1] <= {quo_p[k][W-2:0], ge};
        dvd_p[k+1] <= {dvd_p[k][W-2:0], 1'b0};
        den_p[k+1] <= den_p[k];
        neg_p[k+1] <= neg_p[k];
      end
    end
  end

  // sign and saturation
  logic [W-1:0] mag;
  logic         sat_pos;
  logic         sat_neg;
  assign mag     = quo_p[W];
  assign sat_pos = (mag[W-1:Q_WIDTH-1] != '0);
  assign sat_neg = (mag[W-1:Q_WIDTH] != '0) || (mag[Q_WIDTH-1] && (mag[Q_WIDTH-2:0] != '0));

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_p[W]) begin
        q <= sat_neg ? Q_MIN : Q_WIDTH'(-mag[Q_WIDTH-1:0]);
      end else begin
        q <= sat_pos ? Q_MAX : mag[Q_WIDTH-1:0];
      end
    end
  end

endmodule

[src/rbs_axis_lane.sv]
module rbs_axis_lane import rbs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [THR_WIDTH-1:0]      thr,
  input  logic signed [Q_WIDTH-1:0] o,
  input  logic signed [Q_WIDTH-1:0] d,
  input  logic signed [Q_WIDTH-1:0] lo,
  input  logic signed [Q_WIDTH-1:0] hi,
  output lane_out_t                 res
);

  localparam int LAT = NUM_WIDTH + FRAC_BITS + 2;

  logic signed [NUM_WIDTH-1:0] num_lo;
  logic signed [NUM_WIDTH-1:0] num_hi;
  logic [Q_WIDTH-1:0]          mag;
  logic                        par;
  logic                        pmiss;
  logic signed [Q_WIDTH-1:0]   t_lo;
  logic signed [Q_WIDTH-1:0]   t_hi;
  logic                        par_d   [0:LAT-1];
  logic                        pmiss_d [0:LAT-1];

  // slab numerators and parallel test
  assign num_lo = NUM_WIDTH'(lo) - NUM_WIDTH'(o);
  assign num_hi = NUM_WIDTH'(hi) - NUM_WIDTH'(o);
  assign mag    = d[Q_WIDTH-1] ? Q_WIDTH'(-d) : d;
  assign par    = (d == '0) || (mag < Q_WIDTH'(thr));
  assign pmiss  = par && ((o < lo) || (o > hi));

  rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
    .clk(clk), .en(en), .num(num_lo), .den(d), .q(t_lo)
  );
  rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
    .clk(clk), .en(en), .num(num_hi), .den(d), .q(t_hi)
  );

  // parallel flags follow the divider latency
  always_ff @(posedge clk) begin
    if (en) begin
      par_d[0]   <= par;
      pmiss_d[0] <= pmiss;
      for (int k = 1; k < LAT; k++) begin
        par_d[k]   <= par_d[k-1];
        pmiss_d[k] <= pmiss_d[k-1];
      end
    end
  end

  // ordered slab distances
  always_comb begin
    res.par   = par_d[LAT-1];
    res.pmiss = pmiss_d[LAT-1];
    res.tmin  = (t_lo > t_hi) ? t_hi : t_lo;
    res.tmax  = (t_lo > t_hi) ? t_lo : t_hi;
  end

endmodule

[src/rbs_merge.sv]
module rbs_merge import rbs_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  lane_out_t             lanes [0:NUM_AXES-1],
  output logic                  hit,
  output logic [DIST_WIDTH-1:0] distance
);

  logic signed [Q_WIDTH-1:0] near_t;
  logic signed [Q_WIDTH-1:0] far_t;
  logic                      miss;

  // fold the lanes into one interval
  always_comb begin
    near_t = Q_MIN;
    far_t  = Q_MAX;
    miss   = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (lanes[a].pmiss) begin
        miss = 1'b1;
      end
      if (!lanes[a].par) begin
        if (lanes[a].tmin > near_t) begin
          near_t = lanes[a].tmin;
        end
        if (lanes[a].tmax < far_t) begin
          far_t = lanes[a].tmax;
        end
      end
    end
    if (near_t > far_t) begin
      miss = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!miss && near_t > 0) begin
        hit      <= 1'b1;
        distance <= near_t[DIST_WIDTH-1:0];
      end else if (!miss && far_t > 0) begin
        hit      <= 1'b1;
        distance <= far_t[DIST_WIDTH-1:0];
      end else begin
        hit      <= 1'b0;
        distance <= '0;
      end
    end
  end

endmodule
